/* rtl/complex_gemv_conj_row_mac_top_defines.svh */
// assertion macros for the complex gemv row engine
// expects aclk and aresetn in the scope where a macro is used
`ifndef COMPLEX_GEMV_CONJ_ROW_MAC_TOP_DEFINES_SVH
`define COMPLEX_GEMV_CONJ_ROW_MAC_TOP_DEFINES_SVH

// same-cycle implication
`define CGEMV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cgemv check failed");

// next-cycle implication
`define CGEMV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cgemv check failed");

`endif

/* rtl/cgemv_pkg.sv */
// shared types, constants and helpers for the complex gemv row engine
// no dependencies
`default_nettype none

package cgemv_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int TMP_W     = TERM_W + 2;
    localparam int ACC_W     = 64;
    localparam int ROW_W     = 16;
    localparam int OP_W      = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_RE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_IM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 3'd4;

    // multiplier operations, accumulate phase then output phase
    localparam logic [OP_W-1:0] OP_AR_XR = 4'd0;
    localparam logic [OP_W-1:0] OP_AI_XI = 4'd1;
    localparam logic [OP_W-1:0] OP_AI_XR = 4'd2;
    localparam logic [OP_W-1:0] OP_AR_XI = 4'd3;
    localparam logic [OP_W-1:0] OP_UR_SR = 4'd4;
    localparam logic [OP_W-1:0] OP_UI_SI = 4'd5;
    localparam logic [OP_W-1:0] OP_BR_YR = 4'd6;
    localparam logic [OP_W-1:0] OP_BI_YI = 4'd7;
    localparam logic [OP_W-1:0] OP_UR_SI = 4'd8;
    localparam logic [OP_W-1:0] OP_UI_SR = 4'd9;
    localparam logic [OP_W-1:0] OP_BR_YI = 4'd10;
    localparam logic [OP_W-1:0] OP_BI_YR = 4'd11;

    typedef struct packed {
        logic            vld;
        logic [OP_W-1:0] op;
    } mul_req_t;

    typedef struct packed {
        logic              vld;
        logic [OP_W-1:0]   op;
        logic [TERM_W-1:0] term;
    } mul_res_t;

    typedef struct packed {
        logic neg;
        logic to_im;
    } op_ctrl_t;

    function automatic op_ctrl_t op_ctrl(input logic [OP_W-1:0] op);
        op_ctrl_t c;
        c = '0;
        case (op)
            OP_AR_XR: c = '{neg: 1'b0, to_im: 1'b0};
            OP_AI_XI: c = '{neg: 1'b0, to_im: 1'b0};
            OP_AI_XR: c = '{neg: 1'b0, to_im: 1'b1};
            OP_AR_XI: c = '{neg: 1'b1, to_im: 1'b1};
            OP_UR_SR: c = '{neg: 1'b0, to_im: 1'b0};
            OP_UI_SI: c = '{neg: 1'b1, to_im: 1'b0};
            OP_BR_YR: c = '{neg: 1'b0, to_im: 1'b0};
            OP_BI_YI: c = '{neg: 1'b1, to_im: 1'b0};
            OP_UR_SI: c = '{neg: 1'b0, to_im: 1'b1};
            OP_UI_SR: c = '{neg: 1'b0, to_im: 1'b1};
            OP_BR_YI: c = '{neg: 1'b0, to_im: 1'b1};
            OP_BI_YR: c = '{neg: 1'b0, to_im: 1'b1};
            default:  c = '0;
        endcase
        return c;
    endfunction

    // clamp a wide signed value to the data width
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/cgemv_mul.sv */
// shared signed multiplier with registered product and fixed-point scaling
// depends on cgemv_pkg
`default_nettype none

module cgemv_mul
    import cgemv_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mul_req_t                 req,
    input  wire logic signed [DATA_W-1:0] opa,
    input  wire logic signed [DATA_W-1:0] opb,
    output mul_res_t                      res
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     vld_reg;
    logic [OP_W-1:0]          op_reg;

    assign prod_next = opa * opb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= req.vld;
        end
        prod_reg <= prod_next;
        op_reg   <= req.op;
    end

    // dropping the low fraction bits is an arithmetic shift toward minus infinity
    assign res.vld  = vld_reg;
    assign res.op   = op_reg;
    assign res.term = prod_reg[PROD_W-1:FRAC_BITS];

endmodule

`default_nettype wire

/* rtl/complex_gemv_conj_row_mac_top.sv */
// complex gemv row engine, y := alpha*A*conj(x) + beta*y, one row at a time
// depends on cgemv_pkg, cgemv_mul and complex_gemv_conj_row_mac_top_defines.svh
`default_nettype none
`include "complex_gemv_conj_row_mac_top_defines.svh"

// One request carries a matrix element, the matching x element, the row's old y and a
// last-in-row flag on s_tlast. All arithmetic goes through one 32x32 multiplier: an element
// needs four products, and the last element of a row adds eight more products for
// alpha*sum + beta*y; a new request is taken only once the last one is through, and a row
// result first waits until the output register is free on m_tready. The row result is held
// in an output register, so the next row's elements are taken while it waits. m_tlast marks
// the row that completes a job of num_rows rows. Data and scalars are signed Q16.16, row
// sums 64 bits with saturation, results saturated to 32 bits.
module complex_gemv_conj_row_mac_top
    import cgemv_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [6*DATA_W-1:0]  s_tdata,   // a_re, a_im, x_re, x_im, y_re, y_im
    input  wire logic                 s_tlast,   // last_in_row
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [2*DATA_W-1:0]       m_tdata,   // out_re, out_im
    output logic                      m_tlast    // last_row
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MAC    = 8'b0000_0010,
        ST_MDRAIN = 8'b0000_0100,
        ST_ACC    = 8'b0000_1000,
        ST_LOAD   = 8'b0001_0000,
        ST_FIN    = 8'b0010_0000,
        ST_FDRAIN = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;

    logic signed [DATA_W-1:0] alpha_re_reg, alpha_im_reg, beta_re_reg, beta_im_reg;
    logic [ROW_W-1:0]         num_rows_reg;

    logic signed [DATA_W-1:0] a_re_reg, a_im_reg, x_re_reg, x_im_reg, y_re_reg, y_im_reg;
    logic                     last_in_row_reg;
    logic signed [DATA_W-1:0] s_re_reg, s_im_reg;

    logic signed [TMP_W-1:0]  tmp_re_reg, tmp_re_next, tmp_im_reg, tmp_im_next;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_re_next, acc_im_reg, acc_im_next;
    logic [ROW_W-1:0]         row_cnt_reg, row_cnt_next;

    logic signed [DATA_W-1:0] out_re_reg, out_im_reg;
    logic                     last_row_reg;
    logic                     m_valid_reg, m_valid_next;

    mul_req_t                 mul_req;
    mul_res_t                 mul_res;
    logic signed [DATA_W-1:0] opa, opb;
    op_ctrl_t                 res_ctl;
    logic signed [TMP_W-1:0]  addend;
    logic                     s_fire, out_fire, job_end;
    logic [ROW_W:0]           row_inc;

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                        input logic signed [TMP_W-1:0] t);
        logic signed [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W-TMP_W+1){t[TMP_W-1]}}, t};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return sum[ACC_W-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_fire = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_re_reg <= 32'sd65536;
            alpha_im_reg <= '0;
            beta_re_reg  <= '0;
            beta_im_reg  <= '0;
            num_rows_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALPHA_RE: alpha_re_reg <= cfg_wdata;
                CFG_ALPHA_IM: alpha_im_reg <= cfg_wdata;
                CFG_BETA_RE:  beta_re_reg  <= cfg_wdata;
                CFG_BETA_IM:  beta_im_reg  <= cfg_wdata;
                CFG_NUM_ROWS: num_rows_reg <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        opa = '0;
        opb = '0;
        case (op_reg)
            OP_AR_XR: begin opa = a_re_reg;     opb = x_re_reg; end
            OP_AI_XI: begin opa = a_im_reg;     opb = x_im_reg; end
            OP_AI_XR: begin opa = a_im_reg;     opb = x_re_reg; end
            OP_AR_XI: begin opa = a_re_reg;     opb = x_im_reg; end
            OP_UR_SR: begin opa = alpha_re_reg; opb = s_re_reg; end
            OP_UI_SI: begin opa = alpha_im_reg; opb = s_im_reg; end
            OP_BR_YR: begin opa = beta_re_reg;  opb = y_re_reg; end
            OP_BI_YI: begin opa = beta_im_reg;  opb = y_im_reg; end
            OP_UR_SI: begin opa = alpha_re_reg; opb = s_im_reg; end
            OP_UI_SR: begin opa = alpha_im_reg; opb = s_re_reg; end
            OP_BR_YI: begin opa = beta_re_reg;  opb = y_im_reg; end
            OP_BI_YR: begin opa = beta_im_reg;  opb = y_re_reg; end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    assign mul_req.vld = (state_reg == ST_MAC) || (state_reg == ST_FIN);
    assign mul_req.op  = op_reg;

    cgemv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .opa     (opa),
        .opb     (opb),
        .res     (mul_res)
    );

    assign res_ctl = op_ctrl(mul_res.op);

    always_comb begin
        logic signed [TMP_W-1:0] ext;
        ext    = {{(TMP_W-TERM_W){mul_res.term[TERM_W-1]}}, mul_res.term};
        addend = res_ctl.neg ? -ext : ext;
    end

    assign row_inc = {1'b0, row_cnt_reg} + {{ROW_W{1'b0}}, 1'b1};
    assign job_end = (row_inc >= {1'b0, num_rows_reg});

    // sequencer and datapath next values
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        tmp_re_next  = tmp_re_reg;
        tmp_im_next  = tmp_im_reg;
        acc_re_next  = acc_re_reg;
        acc_im_next  = acc_im_reg;
        row_cnt_next = row_cnt_reg;

        if (mul_res.vld) begin
            if (res_ctl.to_im) begin
                tmp_im_next = tmp_im_reg + addend;
            end else begin
                tmp_re_next = tmp_re_reg + addend;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next  = ST_MAC;
                    op_next     = OP_AR_XR;
                    tmp_re_next = '0;
                    tmp_im_next = '0;
                end
            end
            ST_MAC: begin
                op_next = op_reg + 1'b1;
                if (op_reg == OP_AR_XI) begin
                    state_next = ST_MDRAIN;
                end
            end
            ST_MDRAIN: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_re_next = sat_add(acc_re_reg, tmp_re_reg);
                acc_im_next = sat_add(acc_im_reg, tmp_im_reg);
                state_next  = last_in_row_reg ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                acc_re_next = '0;
                acc_im_next = '0;
                tmp_re_next = '0;
                tmp_im_next = '0;
                op_next     = OP_UR_SR;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                op_next = op_reg + 1'b1;
                if (op_reg == OP_BI_YR) begin
                    state_next = ST_FDRAIN;
                end
            end
            ST_FDRAIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) begin
                    row_cnt_next = job_end ? '0 : row_inc[ROW_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = out_fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_re_reg  <= '0;
            acc_im_reg  <= '0;
            row_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_re_reg  <= acc_re_next;
            acc_im_reg  <= acc_im_next;
            row_cnt_reg <= row_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        tmp_re_reg <= tmp_re_next;
        tmp_im_reg <= tmp_im_next;
        if (s_fire) begin
            a_re_reg        <= s_tdata[0*DATA_W +: DATA_W];
            a_im_reg        <= s_tdata[1*DATA_W +: DATA_W];
            x_re_reg        <= s_tdata[2*DATA_W +: DATA_W];
            x_im_reg        <= s_tdata[3*DATA_W +: DATA_W];
            y_re_reg        <= s_tdata[4*DATA_W +: DATA_W];
            y_im_reg        <= s_tdata[5*DATA_W +: DATA_W];
            last_in_row_reg <= s_tlast;
        end
        if (state_reg == ST_LOAD) begin
            s_re_reg <= sat_data(acc_re_reg);
            s_im_reg <= sat_data(acc_im_reg);
        end
        if (out_fire) begin
            out_re_reg   <= sat_data({{(ACC_W-TMP_W){tmp_re_reg[TMP_W-1]}}, tmp_re_reg});
            out_im_reg   <= sat_data({{(ACC_W-TMP_W){tmp_im_reg[TMP_W-1]}}, tmp_im_reg});
            last_row_reg <= job_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_im_reg, out_re_reg};
    assign m_tlast  = last_row_reg;

    `CGEMV_ASSERT_NEXT(a_accept_starts_mac, s_tvalid && s_tready, state_reg == ST_MAC)
    `CGEMV_ASSERT_NOW(a_result_from_out, $rose(m_tvalid), $past(state_reg) == ST_OUT)
    `CGEMV_ASSERT_NOW(a_product_in_phase, mul_res.vld,
        state_reg == ST_MAC || state_reg == ST_MDRAIN || state_reg == ST_FIN || state_reg == ST_FDRAIN)
    `CGEMV_ASSERT_NEXT(a_acc_exit, state_reg == ST_ACC,
        state_reg == ST_LOAD || state_reg == ST_IDLE)

endmodule

`default_nettype wire
